// File: src/pidv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidv_pkg
// Types and constants shared by the PID step controller and datapath.
// ----------------------------------------------------------------------------
package pidv_pkg;

   localparam int ERR_W    = 16;
   localparam int DT_W     = 16;
   localparam int ACC_W    = 48;
   localparam int MUL_A_W  = 17;
   localparam int MUL_B_W  = 33;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int SUM_W    = 50;
   localparam int DIFF_W   = ERR_W + 1;
   localparam int DIVD_W   = DIFF_W + DT_W;
   localparam int QUO_W    = 32;
   localparam int DERIV_W  = QUO_W + 1;
   localparam int DIV_CNT_W = $clog2(DIVD_W + 1);
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_PROP  = 3'd0,
      CSR_GAIN_INTEG = 3'd1,
      CSR_GAIN_DERIV = 3'd2,
      CSR_OUT_UPPER  = 3'd3,
      CSR_OUT_LOWER  = 3'd4
   } csr_reg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_INTEG,
      S_MPROP,
      S_MILO,
      S_MIHI,
      S_DIV,
      S_MDER,
      S_ADDD,
      S_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_PREV_DT,
      MUL_PROP_E,
      MUL_INT_LO,
      MUL_INT_HI,
      MUL_DER
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_INTEG,
      ACC_SUM_LOAD,
      ACC_SUM_ADD,
      ACC_SUM_SHR16,
      ACC_SUM_SHL8
   } acc_op_type;

   typedef struct packed {
      logic        latch;
      logic        div_start;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        prev_upd;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } sts_type;

endpackage

// File: src/pidv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidv_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidv_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pidv_pkg::DIVD_W-1:0]   dividend,
   input  logic [pidv_pkg::DT_W-1:0]     divisor,
   output logic                          busy,
   output logic [pidv_pkg::DIVD_W-1:0]   quotient
);

   logic [pidv_pkg::DT_W-1:0]      rem_ff, rem_in;
   logic [pidv_pkg::DIVD_W-1:0]    quo_ff, quo_in;
   logic [pidv_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [pidv_pkg::DT_W:0]        trial;
   logic                           fits;

   assign trial = {rem_ff, quo_ff[pidv_pkg::DIVD_W-1]};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = pidv_pkg::DIV_CNT_W'(pidv_pkg::DIVD_W);
      end else if (cnt_ff != '0) begin
         rem_in = fits ? pidv_pkg::DT_W'(trial - {1'b0, divisor})
                       : trial[pidv_pkg::DT_W-1:0];
         quo_in = {quo_ff[pidv_pkg::DIVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

// File: src/pidv_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidv_dp
// PID datapath: state, settings, shared multiplier, accumulators, clamp.
// ----------------------------------------------------------------------------
module pidv_dp #(
   parameter int DT_MIN_THRESHOLD = 7
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pidv_pkg::cmd_type                    cmd,
   output pidv_pkg::sts_type                    sts,
   input  logic signed [pidv_pkg::ERR_W-1:0]    req_error_sample,
   input  logic        [pidv_pkg::DT_W-1:0]     req_step_time,
   input  logic                                 csr_write,
   input  logic [pidv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pidv_pkg::ERR_W-1:0]           csr_data,
   output logic signed [pidv_pkg::ERR_W-1:0]    rsp_control_out,
   output logic                                 rsp_clamped
);

   localparam logic [pidv_pkg::DT_W-1:0] DT_MIN = pidv_pkg::DT_W'(DT_MIN_THRESHOLD);
   localparam logic signed [pidv_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(pidv_pkg::ACC_W-1){1'b1}}};
   localparam logic signed [pidv_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(pidv_pkg::ACC_W-1){1'b0}}};

   logic signed [pidv_pkg::ERR_W-1:0]  gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   logic signed [pidv_pkg::ERR_W-1:0]  out_upper_ff, out_lower_ff;
   logic signed [pidv_pkg::ERR_W-1:0]  e_ff, prev_ff, prev_in;
   logic        [pidv_pkg::DT_W-1:0]   dt_ff;
   logic signed [pidv_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [pidv_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [pidv_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                               deriv_en_ff, deriv_neg_ff;
   logic signed [pidv_pkg::ERR_W-1:0]  ctl_ff, ctl_in;
   logic                               clamp_ff, clamp_in;

   logic signed [pidv_pkg::DIFF_W-1:0]  diff;
   logic        [pidv_pkg::DIFF_W-1:0]  mag;
   logic                                div_go;
   logic                                div_busy;
   logic        [pidv_pkg::DIVD_W-1:0]  quo;
   logic signed [pidv_pkg::DERIV_W-1:0] deriv_mag, deriv;
   logic signed [pidv_pkg::MUL_A_W-1:0] mul_a;
   logic signed [pidv_pkg::MUL_B_W-1:0] mul_b;
   logic signed [pidv_pkg::ACC_W:0]     acc_sum;
   logic signed [pidv_pkg::SUM_W-1:0]   prod_ext, prod_shr, prod_shl;
   logic signed [pidv_pkg::SUM_W-1:0]   upper_ext, lower_ext;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff  <= '0;
         gain_integ_ff <= '0;
         gain_deriv_ff <= '0;
         out_upper_ff  <= 16'sh7FFF;
         out_lower_ff  <= 16'sh8000;
      end else if (csr_write) begin
         unique case (csr_index)
            pidv_pkg::CSR_GAIN_PROP:  gain_prop_ff  <= csr_data;
            pidv_pkg::CSR_GAIN_INTEG: gain_integ_ff <= csr_data;
            pidv_pkg::CSR_GAIN_DERIV: gain_deriv_ff <= csr_data;
            pidv_pkg::CSR_OUT_UPPER:  out_upper_ff  <= csr_data;
            pidv_pkg::CSR_OUT_LOWER:  out_lower_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // derivative division
   assign diff   = {e_ff[pidv_pkg::ERR_W-1], e_ff} - {prev_ff[pidv_pkg::ERR_W-1], prev_ff};
   assign mag    = diff[pidv_pkg::DIFF_W-1] ? pidv_pkg::DIFF_W'(-diff) : diff;
   assign div_go = cmd.div_start && (dt_ff > DT_MIN);

   pidv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend ({mag, {pidv_pkg::DT_W{1'b0}}}),
      .divisor  (dt_ff),
      .busy     (div_busy),
      .quotient (quo)
   );

   assign sts.div_busy = div_busy;

   assign deriv_mag = deriv_en_ff ? {1'b0, quo[pidv_pkg::QUO_W-1:0]} : '0;
   assign deriv     = deriv_neg_ff ? -deriv_mag : deriv_mag;

   // shared multiplier
   always_comb begin
      unique case (cmd.mul_sel)
         pidv_pkg::MUL_PREV_DT: begin
            mul_a = {prev_ff[pidv_pkg::ERR_W-1], prev_ff};
            mul_b = {{(pidv_pkg::MUL_B_W-pidv_pkg::DT_W){1'b0}}, dt_ff};
         end
         pidv_pkg::MUL_PROP_E: begin
            mul_a = {gain_prop_ff[pidv_pkg::ERR_W-1], gain_prop_ff};
            mul_b = {{(pidv_pkg::MUL_B_W-pidv_pkg::ERR_W){e_ff[pidv_pkg::ERR_W-1]}}, e_ff};
         end
         pidv_pkg::MUL_INT_LO: begin
            mul_a = {gain_integ_ff[pidv_pkg::ERR_W-1], gain_integ_ff};
            mul_b = {{(pidv_pkg::MUL_B_W-24){1'b0}}, acc_ff[23:0]};
         end
         pidv_pkg::MUL_INT_HI: begin
            mul_a = {gain_integ_ff[pidv_pkg::ERR_W-1], gain_integ_ff};
            mul_b = {{(pidv_pkg::MUL_B_W-24){acc_ff[pidv_pkg::ACC_W-1]}}, acc_ff[47:24]};
         end
         pidv_pkg::MUL_DER: begin
            mul_a = {gain_deriv_ff[pidv_pkg::ERR_W-1], gain_deriv_ff};
            mul_b = deriv;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // accumulation
   assign acc_sum  = {acc_ff[pidv_pkg::ACC_W-1], acc_ff} + prod_ff[pidv_pkg::ACC_W:0];
   assign prod_ext = prod_ff;
   assign prod_shr = {{16{prod_ff[pidv_pkg::PROD_W-1]}}, prod_ff[pidv_pkg::PROD_W-1:16]};
   assign prod_shl = {prod_ff[41:0], 8'b0};

   always_comb begin
      acc_in = acc_ff;
      sum_in = sum_ff;
      unique case (cmd.acc_op)
         pidv_pkg::ACC_INTEG: begin
            if (acc_sum[pidv_pkg::ACC_W] != acc_sum[pidv_pkg::ACC_W-1]) begin
               acc_in = acc_sum[pidv_pkg::ACC_W] ? ACC_MIN : ACC_MAX;
            end else begin
               acc_in = acc_sum[pidv_pkg::ACC_W-1:0];
            end
         end
         pidv_pkg::ACC_SUM_LOAD:  sum_in = prod_ext;
         pidv_pkg::ACC_SUM_ADD:   sum_in = sum_ff + prod_ext;
         pidv_pkg::ACC_SUM_SHR16: sum_in = sum_ff + prod_shr;
         pidv_pkg::ACC_SUM_SHL8:  sum_in = sum_ff + prod_shl;
         default: ;
      endcase
   end

   // previous error and integral both zero: new error becomes the previous
   always_comb begin
      prev_in = prev_ff;
      if (cmd.latch) begin
         if (prev_ff == '0 && acc_ff == '0) begin
            prev_in = req_error_sample;
         end
      end else if (cmd.prev_upd) begin
         prev_in = e_ff;
      end
   end

   // output clamp
   assign upper_ext = {{26{out_upper_ff[pidv_pkg::ERR_W-1]}}, out_upper_ff, 8'b0};
   assign lower_ext = {{26{out_lower_ff[pidv_pkg::ERR_W-1]}}, out_lower_ff, 8'b0};

   always_comb begin
      ctl_in   = ctl_ff;
      clamp_in = clamp_ff;
      if (cmd.rsp_load) begin
         priority if (sum_ff > upper_ext) begin
            ctl_in   = out_upper_ff;
            clamp_in = 1'b1;
         end else if (sum_ff < lower_ext) begin
            ctl_in   = out_lower_ff;
            clamp_in = 1'b1;
         end else begin
            ctl_in   = sum_ff[23:8];
            clamp_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         acc_ff  <= '0;
      end else begin
         prev_ff <= prev_in;
         acc_ff  <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         e_ff  <= req_error_sample;
         dt_ff <= req_step_time;
      end
      if (cmd.div_start) begin
         deriv_en_ff  <= (dt_ff > DT_MIN);
         deriv_neg_ff <= diff[pidv_pkg::DIFF_W-1];
      end
      prod_ff  <= prod_in;
      sum_ff   <= sum_in;
      ctl_ff   <= ctl_in;
      clamp_ff <= clamp_in;
   end

   assign rsp_control_out = ctl_ff;
   assign rsp_clamped     = clamp_ff;

endmodule

// File: src/pidv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidv_ctrl
// Sequencer for one PID step and the handshakes of both channels.
// ----------------------------------------------------------------------------
module pidv_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pidv_pkg::sts_type sts,
   output pidv_pkg::cmd_type cmd
);

   pidv_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pidv_pkg::S_IDLE:  if (req_valid) state_in = pidv_pkg::S_PREP;
         pidv_pkg::S_PREP:  state_in = pidv_pkg::S_INTEG;
         pidv_pkg::S_INTEG: state_in = pidv_pkg::S_MPROP;
         pidv_pkg::S_MPROP: state_in = pidv_pkg::S_MILO;
         pidv_pkg::S_MILO:  state_in = pidv_pkg::S_MIHI;
         pidv_pkg::S_MIHI:  state_in = pidv_pkg::S_DIV;
         pidv_pkg::S_DIV:   if (!sts.div_busy) state_in = pidv_pkg::S_MDER;
         pidv_pkg::S_MDER:  state_in = pidv_pkg::S_ADDD;
         pidv_pkg::S_ADDD:  state_in = pidv_pkg::S_OUT;
         pidv_pkg::S_OUT:   if (slot_free) state_in = pidv_pkg::S_IDLE;
         default:           state_in = pidv_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         pidv_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         pidv_pkg::S_PREP: begin
            cmd.div_start = 1'b1;
            cmd.mul_sel   = pidv_pkg::MUL_PREV_DT;
         end
         pidv_pkg::S_INTEG: begin
            cmd.acc_op   = pidv_pkg::ACC_INTEG;
            cmd.prev_upd = 1'b1;
            cmd.mul_sel  = pidv_pkg::MUL_PROP_E;
         end
         pidv_pkg::S_MPROP: begin
            cmd.acc_op  = pidv_pkg::ACC_SUM_LOAD;
            cmd.mul_sel = pidv_pkg::MUL_INT_LO;
         end
         pidv_pkg::S_MILO: begin
            cmd.acc_op  = pidv_pkg::ACC_SUM_SHR16;
            cmd.mul_sel = pidv_pkg::MUL_INT_HI;
         end
         pidv_pkg::S_MIHI: cmd.acc_op = pidv_pkg::ACC_SUM_SHL8;
         pidv_pkg::S_DIV:  ;
         pidv_pkg::S_MDER: cmd.mul_sel = pidv_pkg::MUL_DER;
         pidv_pkg::S_ADDD: cmd.acc_op = pidv_pkg::ACC_SUM_ADD;
         pidv_pkg::S_OUT:  cmd.rsp_load = slot_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pidv_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/pid_step_variable_dt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_step_variable_dt
// PID controller step with variable time step and clamped output.
// ----------------------------------------------------------------------------
// One error word and time step in, one clamped control word out. A new word
// can be taken only after the result of the last one is loaded, at the
// earliest in the cycle after the load. The derivative uses a 33-step restoring
// divider; with step_time at or below DT_MIN_THRESHOLD the divider is skipped.
// The five products share one 17 x 33 multiplier. A finished result waits in
// the output register while the next word is taken in; the word after that
// stalls until the receiver takes it. Settings may be written at any time the
// block is idle and are taken every cycle.
module pid_step_variable_dt #(
   parameter int DT_MIN_THRESHOLD = 7
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [pidv_pkg::ERR_W-1:0]    req_error_sample,
   input  logic        [pidv_pkg::DT_W-1:0]     req_step_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pidv_pkg::ERR_W-1:0]    rsp_control_out,
   output logic                                 rsp_clamped,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pidv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pidv_pkg::ERR_W-1:0]           csr_data
);

   pidv_pkg::cmd_type cmd;
   pidv_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   pidv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pidv_dp #(
      .DT_MIN_THRESHOLD (DT_MIN_THRESHOLD)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_error_sample (req_error_sample),
      .req_step_time    (req_step_time),
      .csr_write        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_control_out  (rsp_control_out),
      .rsp_clamped      (rsp_clamped)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken again straight after a word");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result loaded without return to idle");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten while waiting");

endmodule
